>>> hdl/pcm_sample_to_float_converter_assert.svh
// assertion macros for the pcm sample to float converter
`ifndef PCM_SAMPLE_TO_FLOAT_CONVERTER_ASSERT_SVH
`define PCM_SAMPLE_TO_FLOAT_CONVERTER_ASSERT_SVH

// implication checked every clock outside reset
`define PSF_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication checked outside reset
`define PSF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/psf_pkg.sv
// shared types, format codes and constants for the sample converter
package psf_pkg;

  typedef enum logic [2:0] {
    FMT_U8  = 3'd0,
    FMT_S16 = 3'd1,
    FMT_S32 = 3'd2,
    FMT_F32 = 3'd3,
    FMT_F64 = 3'd4
  } sample_fmt_t;

  localparam int unsigned FMT_W       = 3;
  localparam logic [FMT_W-1:0] FMT_RESET = 3'd1;
  localparam logic [31:0] SGL_INF     = 32'h7F80_0000;
  localparam logic [31:0] SGL_QNAN    = 32'h7FC0_0000;

endpackage

>>> hdl/pcm_sample_to_float_converter.sv
// top level of the pcm sample to float converter
// Converts one raw audio sample per item to IEEE binary32 bits. An item is
// accepted every cycle when the input register is empty or the output register
// is empty or being drained, so throughput is one item per clock while results
// drain, via the input register, then the result register; the single pass of
// rounding logic between them sets the clock. cfg_we writes the format (reset
// s16); codes 5 to 7 yield zero with the unsupported flag. tlast is copied.
module pcm_sample_to_float_converter
  import psf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // raw_sample
  input  logic        in_tlast,   // last_in
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // float_bits
  output logic        out_tlast,  // last_out
  output logic        out_tuser   // unsupported
);
`include "pcm_sample_to_float_converter_assert.svh"

  logic [2:0]  fmt_r;
  // input stage
  logic        s1_vld_r;
  logic [63:0] s1_raw_r;
  logic        s1_last_r;
  // result stage
  logic        s2_vld_r;
  logic [31:0] s2_bits_r;
  logic        s2_last_r;
  logic        s2_unsup_r;

  logic        s2_free, s1_free;
  logic [31:0] conv_bits;
  logic        conv_unsup;

  assign s2_free   = ~s2_vld_r | out_tready;
  assign s1_free   = ~s1_vld_r | s2_free;
  assign in_tready = s1_free;

  psf_convert u_conv (
    .fmt    (fmt_r),
    .raw    (s1_raw_r),
    .result (conv_bits),
    .unsup  (conv_unsup)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r    <= FMT_RESET;
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      if (cfg_we) fmt_r <= cfg_wdata;
      if (s1_free) s1_vld_r <= in_tvalid;
      if (s2_free) s2_vld_r <= s1_vld_r;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (s1_free && in_tvalid) begin
      s1_raw_r  <= in_tdata;
      s1_last_r <= in_tlast;
    end
    if (s2_free && s1_vld_r) begin
      s2_bits_r  <= conv_bits;
      s2_last_r  <= s1_last_r;
      s2_unsup_r <= conv_unsup;
    end
  end

  assign out_tvalid = s2_vld_r;
  assign out_tdata  = s2_bits_r;
  assign out_tlast  = s2_last_r;
  assign out_tuser  = s2_unsup_r;

  `PSF_ASSERT_NEXT(a_hold, out_tvalid && !out_tready, out_tvalid, "result dropped while stalled")
  `PSF_ASSERT_IMPL(a_unsup_zero, out_tvalid && out_tuser, out_tdata == 32'd0, "unsupported nonzero")
  `PSF_ASSERT_NEXT(a_advance, s1_vld_r && s2_free, s2_vld_r, "stage one item lost")

endmodule

>>> hdl/psf_convert.sv
// combinational conversion of one raw sample to binary32 bits
module psf_convert
  import psf_pkg::*;
(
  input  logic [2:0]  fmt,
  input  logic [63:0] raw,
  output logic [31:0] result,
  output logic        unsup
);

  // all integer formats reduce to sign + 32-bit magnitude * 2^-e
  logic        int_sign;
  logic [31:0] int_mag;
  logic [5:0]  int_lz;
  logic [31:0] int_norm;
  logic [7:0]  int_exp;
  logic [24:0] int_rnd;
  logic [31:0] int_bits;
  logic [4:0]  int_escale;
  logic        int_g, int_st;

  logic        d_sign;
  logic [10:0] d_ef;
  logic [51:0] d_frac;
  logic [52:0] d_sig;
  logic signed [12:0] d_bexp;
  logic [5:0]  d_sh;
  logic [78:0] d_wide;
  logic [23:0] d_q;
  logic        d_g, d_st;
  logic [24:0] d_rq;
  logic [8:0]  d_e;
  logic [31:0] d_bits;
  logic [32:0] d_sum;

  always_comb begin
    int_sign   = 1'b0;
    int_mag    = '0;
    int_escale = 5'd15;
    case (fmt)
      FMT_U8: begin
        int_sign   = ~raw[7];
        int_mag    = raw[7] ? {25'd0, raw[6:0]} : 32'(9'd128 - {1'b0, raw[7:0]});
        int_escale = 5'd7;
      end
      FMT_S32: begin
        int_sign   = raw[31];
        int_mag    = raw[31] ? (~raw[31:0] + 32'd1) : raw[31:0];
        int_escale = 5'd31;
      end
      default: begin
        int_sign   = raw[15];
        int_mag    = {16'd0, raw[15] ? (~raw[15:0] + 16'd1) : raw[15:0]};
        int_escale = 5'd15;
      end
    endcase
  end

  always_comb begin
    int_lz = 6'd32;
    for (int i = 0; i < 32; i++) begin
      if (int_mag[i]) int_lz = 6'(31 - i);
    end
    int_norm = int_mag << int_lz[4:0];
    int_g    = int_norm[7];
    int_st   = |int_norm[6:0];
    int_rnd  = {1'b0, int_norm[31:8]} + 25'(int_g & (int_st | int_norm[8]));
    // value = norm * 2^(31 - lz - escale); biased exp = 127 + 31 - lz - escale
    int_exp  = 8'(9'd158 - 9'(int_lz) - 9'(int_escale));
    if (int_mag == '0) begin
      int_bits = {int_sign, 31'd0};
    end else if (int_rnd[24]) begin
      int_bits = {int_sign, int_exp + 8'd1, 23'd0};
    end else begin
      int_bits = {int_sign, int_exp, int_rnd[22:0]};
    end
  end

  always_comb begin
    d_sign = raw[63];
    d_ef   = raw[62:52];
    d_frac = raw[51:0];
    d_sig  = {d_ef != 11'd0, d_frac};
    // single biased exponent of a normal sig
    d_bexp = 13'(signed'({2'b0, d_ef})) - 13'sd896;
    if (d_ef == 11'd0) d_bexp = -13'sd895;
    // subnormal shift when biased exp <= 0
    if (d_bexp >= 13'sd1) d_sh = 6'd0;
    else if (d_bexp < -13'sd25) d_sh = 6'd26;
    else d_sh = 6'(13'sd1 - d_bexp);
    d_wide = {d_sig, 26'd0} >> d_sh;
    d_q    = d_wide[78:55];
    d_g    = d_wide[54];
    d_st   = |d_wide[53:0];
    d_rq   = {1'b0, d_q} + 25'(d_g & (d_st | d_q[0]));
    d_e    = (d_bexp >= 13'sd1) ? 9'(d_bexp) : 9'd0;
    // exponent field plus mantissa, carry moves exponent naturally
    d_sum  = ({24'd0, d_e} << 23)
             + {8'd0, d_rq} - ((d_e != 9'd0) ? 33'h80_0000 : 33'd0);
    if (d_ef == 11'h7FF) begin
      d_bits = (d_frac == '0) ? {d_sign, SGL_INF[30:0]}
               : ({d_sign, 31'd0} | SGL_QNAN | {9'd0, d_frac[51:29]});
    end else if (d_ef > 11'd1150 || d_sum >= 33'(SGL_INF)) begin
      d_bits = {d_sign, SGL_INF[30:0]};
    end else begin
      d_bits = {d_sign, d_sum[30:0]};
    end
  end

  always_comb begin
    unsup  = 1'b0;
    result = '0;
    case (fmt) inside
      FMT_U8, FMT_S16, FMT_S32: result = int_bits;
      FMT_F32: result = raw[31:0];
      FMT_F64: result = d_bits;
      default: unsup = 1'b1;
    endcase
  end

endmodule

>>> tb/sv/tb_pcm_sample_to_float_converter.sv
// testbench for the pcm sample to float converter: scoreboard with bit-exact predictor
`timescale 1ns / 100ps

module tb_pcm_sample_to_float_converter
  import psf_pkg::*;
();

  typedef struct packed {
    logic [31:0] fbits;
    logic        last;
    logic        unsup;
  } conv_result_t;

  // scoreboard: holds predicted conversions and compares arriving results
  class conv_scoreboard;
    conv_result_t pending[$];
    int           mismatches;

    function int msb_of(logic [63:0] m);
      int p;
      p = 0;
      for (int i = 0; i < 64; i++) if (m[i]) p = i;
      return p;
    endfunction

    // round sign * m * 2^e to binary32, ties to even
    function logic [31:0] round_single(logic [31:0] sgn, logic [63:0] m, int e);
      int          sh;
      logic [63:0] q, rem, half, bits;
      if (m == 0) return sgn;
      sh = msb_of(m) - 23;
      if (sh < -149 - e) sh = -149 - e;
      if (sh <= 0) q = m << (-sh);
      else if (sh > 64) q = 0;
      else if (sh == 64) q = (m > 64'h8000_0000_0000_0000) ? 64'd1 : 64'd0;
      else begin
        rem  = m & ((64'd1 << sh) - 64'd1);
        half = 64'd1 << (sh - 1);
        q    = m >> sh;
        if (rem > half || (rem == half && q[0])) q = q + 64'd1;
      end
      bits = (64'(e + sh + 149) << 23) + q;
      if (bits >= 64'(SGL_INF)) bits = 64'(SGL_INF);
      return sgn | bits[31:0];
    endfunction

    function logic [31:0] scale_int(longint v, int e);
      if (v < 0) return round_single(32'h8000_0000, 64'(-v), e);
      return round_single(32'd0, 64'(v), e);
    endfunction

    function logic [31:0] narrow_double(logic [63:0] d);
      logic [31:0] sgn;
      logic [10:0] ex;
      logic [63:0] frac;
      sgn  = {d[63], 31'd0};
      ex   = d[62:52];
      frac = {12'd0, d[51:0]};
      if (ex == 11'h7FF) begin
        if (frac == 0) return sgn | SGL_INF;
        return sgn | SGL_QNAN | 32'(frac >> 29);
      end
      if (ex == 0) return round_single(sgn, frac, -1074);
      return round_single(sgn, frac | 64'h0010_0000_0000_0000, int'(ex) - 1075);
    endfunction

    function void note_sample(logic [2:0] fmt, logic [63:0] raw, logic last);
      conv_result_t r;
      r.fbits = 0;
      r.last  = last;
      r.unsup = 0;
      case (fmt)
        FMT_U8:  r.fbits = scale_int(longint'(raw[7:0]) - 128, -7);
        FMT_S16: r.fbits = scale_int(longint'($signed(raw[15:0])), -15);
        FMT_S32: r.fbits = scale_int(longint'($signed(raw[31:0])), -31);
        FMT_F32: r.fbits = raw[31:0];
        FMT_F64: r.fbits = narrow_double(raw);
        default: r.unsup = 1;
      endcase
      pending.push_back(r);
    endfunction

    function void check_result(conv_result_t got);
      conv_result_t exp_r;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
        return;
      end
      exp_r = pending.pop_front();
      if (got !== exp_r) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp bits %h last %b unsup %b, got bits %h last %b unsup %b",
                   exp_r.fbits, exp_r.last, exp_r.unsup, got.fbits, got.last, got.unsup);
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        cfg_we = 0;
  logic [2:0]  cfg_wdata = 0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [63:0] in_tdata = 0;
  logic        in_tlast = 0;
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [31:0] out_tdata;
  logic        out_tlast;
  logic        out_tuser;

  conv_scoreboard sb;
  logic [2:0] cur_fmt;           // format the block is known to hold
  int         send_idle_pct;     // chance per cycle that the sender holds back
  int         recv_idle_pct;     // chance per cycle that the receiver stalls
  int         quiet_cycles;      // watchdog: cycles with no handshake
  bit         timed_out;

  localparam int WATCHDOG_LIMIT = 2000;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  pcm_sample_to_float_converter uut (
    .clk, .rst_n, .cfg_we, .cfg_wdata,
    .in_tvalid, .in_tready, .in_tdata, .in_tlast,
    .out_tvalid, .out_tready, .out_tdata, .out_tlast, .out_tuser
  );

  // rising edge: score accepted items and results, run the watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_sample(cur_fmt, in_tdata, in_tlast);
      if (out_tvalid && out_tready) sb.check_result({out_tdata, out_tlast, out_tuser});
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) timed_out = 1;
    end
  end

  // receiver stalls at random, on the falling edge
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // present one item and hold it until accepted
  task automatic send_sample(logic [63:0] raw, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 0;
      @(negedge clk);
    end
    in_tvalid <= 1;
    in_tdata  <= raw;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // stop sending and wait until all results are in, then let the block idle
  task automatic drain();
    in_tvalid <= 0;
    while (sb.pending.size() != 0 && !timed_out) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // register write while idle
  task automatic set_format(logic [2:0] fmt);
    drain();
    cfg_we    <= 1;
    cfg_wdata <= fmt;
    @(negedge clk);
    cfg_we  <= 0;
    cur_fmt = fmt;
  endtask

  // random sample, biased toward interesting bit patterns for the format
  function automatic logic [63:0] pick_sample();
    logic [63:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(9))
      0: r[62:52] = 11'h7FF;                     // double inf or nan
      1: r[62:52] = 11'd0;                       // double subnormal
      2: r[62:52] = 11'(896 + $urandom_range(40)); // near the single subnormal boundary
      3: r[62:52] = 11'(1150 + $urandom_range(20)); // near single overflow
      4: r[62:52] = 11'(1023 + $urandom_range(60) - 30);
      5: r[28:0] = 29'h1000_0000;                // tie in the double fraction
      6: r[7:0] = 8'd0;                          // zero low byte for s32
      default: ;
    endcase
    return r;
  endfunction

  task automatic random_phase(int n);
    for (int i = 0; i < n && !timed_out; i++)
      send_sample(pick_sample(), $urandom_range(7) == 0);
  endtask

  initial begin
    logic [63:0] corners[$];
    sb = new();
    cur_fmt = FMT_RESET;
    send_idle_pct = 38;
    recv_idle_pct = 55;
    quiet_cycles = 0;
    timed_out = 0;
    repeat (2) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // directed: extremes, unused high bits, double special values
    corners = '{64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0080,
                64'hABCD_0000_0000_007F, 64'h0000_0000_0000_8000,
                64'h0000_0000_8000_0000, 64'h0000_0000_7FFF_FFFF,
                64'h7FF0_0000_0000_0000, 64'hFFF0_0000_0000_0000,
                64'h7FF8_0000_2000_0001, 64'hFFF0_0000_0000_0001,
                64'h47F0_0000_0000_0000, 64'h0000_0000_0000_0001,
                64'h36A0_0000_0000_0000, 64'h3690_0000_0000_0001,
                64'h3FF0_0000_1000_0000, 64'h3FF0_0000_3000_0000,
                64'h0000_0000_7FC0_0001, 64'h8000_0000_0000_0000};
    // s16 from reset first, without writing the register
    foreach (corners[i]) if (i < 6) send_sample(corners[i], i[0]);
    for (int f = 0; f < 8; f++) begin
      set_format(f[2:0]);
      foreach (corners[i]) if (f == FMT_F64 || i < 7) send_sample(corners[i], i[0]);
    end

    // random phases with the three idling patterns across several formats
    send_idle_pct = 38;
    recv_idle_pct = 55;
    for (int f = 0; f < 8; f++) begin
      set_format(f[2:0]);
      random_phase(f == FMT_F64 || f == FMT_S32 ? 25 : 12);
    end
    send_idle_pct = 55;
    recv_idle_pct = 38;
    set_format(FMT_F64);
    random_phase(60);
    drain();                     // sender waits for every result
    random_phase(40);
    set_format(FMT_S32);
    random_phase(50);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_format(3'd7);
    random_phase(10);
    set_format(FMT_U8);
    random_phase(20);
    set_format(FMT_F64);
    random_phase(60);
    drain();

    if (timed_out || sb.mismatches != 0 || sb.pending.size() != 0) begin
      $display("FAIL pcm_sample_to_float_converter");
    end else begin
      $display("PASS pcm_sample_to_float_converter");
    end
    $finish;
  end

  // watchdog end for a block that stops answering
  initial begin
    wait (timed_out);
    #1;
    $display("FAIL pcm_sample_to_float_converter");
    $finish;
  end

endmodule

>>> pcm_sample_to_float_converter.f
+incdir+hdl
hdl/psf_pkg.sv
hdl/psf_convert.sv
hdl/pcm_sample_to_float_converter.sv
tb/sv/tb_pcm_sample_to_float_converter.sv
